// ----- design/assert_macros.svh -----
// Assertion macros used by the find-and-replace top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define SFR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- design/sfr_pkg.sv -----
// Types and constants shared by the find-and-replace modules.
package sfr_pkg;

  // Configuration port widths
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  // Replacement text and emitted runs hold at most eight bytes
  localparam int MaxRun   = 8;
  localparam int LenW     = 4;
  localparam int RunIdxW  = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPatBytes = 2'd0,
    RegPatLen   = 2'd1,
    RegRepBytes = 2'd2,
    RegRepLen   = 2'd3
  } sfr_reg_e;

  // One run of output bytes, produced by the front and played out by the back
  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [LenW-1:0]        len;
    logic                   text_end;
  } sfr_cmd_t;

endpackage

// ----- design/sfr_front.sv -----
// Front end: configuration registers, pending window, pattern compare, run builder.
module sfr_front #(
  parameter int MAX_LEN = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sfr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_final_i,
  output logic                          cmd_valid_o,
  output sfr_pkg::sfr_cmd_t             cmd_o,
  input  logic                          cmd_ready_i
);
  import sfr_pkg::*;

  localparam int CntW = $clog2(MAX_LEN + 1);

  logic [CfgDataW-1:0] pat_bytes_q;
  logic [LenW-1:0]     pat_len_q;
  logic [CfgDataW-1:0] rep_bytes_q;
  logic [LenW-1:0]     rep_len_q;

  logic [7:0]          pend_q [MAX_LEN];
  logic [7:0]          pend_d [MAX_LEN];
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     count_d;

  logic [7:0]          win [MAX_LEN];
  logic [CntW-1:0]     plen;
  logic [LenW-1:0]     rlen;
  logic [CntW-1:0]     cnt1;
  logic                full;
  logic                match;
  logic                emit;
  logic                in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd_ready_i;
  assign in_acc      = in_valid_i && cmd_ready_i;
  assign cmd_valid_o = in_valid_i && emit;

  // Clamp the configured lengths to their legal ranges
  always_comb begin
    if (pat_len_q == '0) begin
      plen = CntW'(1);
    end else if (pat_len_q > LenW'(MAX_LEN)) begin
      plen = CntW'(MAX_LEN);
    end else begin
      plen = CntW'(pat_len_q);
    end
    if (rep_len_q == '0) begin
      rlen = LenW'(1);
    end else if (rep_len_q > LenW'(MaxRun)) begin
      rlen = LenW'(MaxRun);
    end else begin
      rlen = rep_len_q;
    end
  end

  // Append the new byte and compare the window against the pattern
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      win[i] = (CntW'(i) == count_q) ? in_byte_i : pend_q[i];
    end
    cnt1  = count_q + CntW'(1);
    full  = (cnt1 >= plen);
    match = 1'b1;
    for (int i = 0; i < MAX_LEN; i++) begin
      if ((CntW'(i) < plen) && (win[i] != pat_bytes_q[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // Build the output run and the next window
  always_comb begin
    cmd_o.bytes    = '0;
    cmd_o.len      = '0;
    cmd_o.text_end = in_final_i;
    emit           = 1'b0;
    pend_d         = win;
    count_d        = cnt1;
    if (full && match) begin
      // Matched: emit the replacement and empty the window
      cmd_o.bytes = rep_bytes_q;
      cmd_o.len   = rlen;
      emit        = 1'b1;
      count_d     = '0;
    end else if (full) begin
      // No match: emit the oldest byte, or the whole window on a final byte
      emit = 1'b1;
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        pend_d[i] = win[i+1];
      end
      count_d = cnt1 - CntW'(1);
      if (in_final_i) begin
        for (int i = 0; i < MAX_LEN; i++) begin
          cmd_o.bytes[i] = win[i];
        end
        cmd_o.len = LenW'(cnt1);
      end else begin
        cmd_o.bytes[0] = win[0];
        cmd_o.len      = LenW'(1);
      end
    end else if (in_final_i) begin
      // Window not full yet: flush it on a final byte
      emit = 1'b1;
      for (int i = 0; i < MAX_LEN; i++) begin
        cmd_o.bytes[i] = win[i];
      end
      cmd_o.len = LenW'(cnt1);
    end
    if (in_final_i) begin
      count_d = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LenW'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= LenW'(1);
    end else if (cfg_valid_i) begin
      case (sfr_reg_e'(cfg_index_i))
        RegPatBytes: pat_bytes_q <= cfg_data_i;
        RegPatLen:   pat_len_q   <= cfg_data_i[LenW-1:0];
        RegRepBytes: rep_bytes_q <= cfg_data_i;
        RegRepLen:   rep_len_q   <= cfg_data_i[LenW-1:0];
        default:     ;
      endcase
    end
  end

  // Pending count: drop the window on any pattern length write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && (sfr_reg_e'(cfg_index_i) == RegPatLen)) begin
      count_q <= '0;
    end else if (in_acc) begin
      count_q <= count_d;
    end
  end

  // Pending bytes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ----- design/sfr_queue.sv -----
// Two-entry queue of output runs between the front and the back.
module sfr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sfr_pkg::sfr_cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output sfr_pkg::sfr_cmd_t pop_cmd_o
);
  import sfr_pkg::*;

  sfr_cmd_t   mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // Store the pushed run
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- design/sfr_back.sv -----
// Back end: plays out each queued run one byte per cycle while the output is ready.
module sfr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  sfr_pkg::sfr_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_run_end_o,
  output logic              out_text_end_o
);
  import sfr_pkg::*;

  sfr_cmd_t           cmd_q;
  logic [RunIdxW-1:0] idx_q;
  logic               busy_q;
  logic               last;

  assign last           = (({1'b0, idx_q} + LenW'(1)) == cmd_q.len);
  assign cmd_ready_o    = !busy_q || (out_ready_i && last);
  assign out_valid_o    = busy_q;
  assign out_byte_o     = cmd_q.bytes[idx_q];
  assign out_run_end_o  = last;
  assign out_text_end_o = last && cmd_q.text_end;

  // Load the next run or advance through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (cmd_valid_i && cmd_ready_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + RunIdxW'(1);
      end
    end
  end

  // Hold the run payload
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      cmd_q <= cmd_i;
    end
  end

endmodule

// ----- design/stream_find_replace.sv -----
// Streaming find-and-replace top level: front end, run queue, back end.
//
// Takes one text byte per cycle and replaces every non-overlapping match of
// the configured pattern (1..MAX_LEN bytes) with the replacement (1..8 bytes).
// The front end compares the whole pending window in parallel, so a request
// is taken every cycle while the two-entry run queue has room. The back end
// sends one output byte per cycle while the output is ready; a match emits
// the whole replacement and a final byte flushes up to eight pending bytes,
// so such a request holds the output until all its bytes are sent, and the
// input stalls once the queue fills behind it. A plain byte yields a single
// output byte; one that only fills the window yields none. Write configuration
// only while no text is in flight; a pattern length write drops pending bytes.
`include "assert_macros.svh"

module stream_find_replace #(
  parameter int MAX_LEN = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sfr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_final_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_run_end_o,
  output logic                          out_text_end_o
);
  import sfr_pkg::*;

  logic     f_valid;
  logic     f_ready;
  sfr_cmd_t f_cmd;
  logic     b_valid;
  logic     b_ready;
  sfr_cmd_t b_cmd;

  // Classify each input byte into an output run
  sfr_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_final_i  (in_final_i),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_ready)
  );

  // Decouple front and back
  sfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  // Serialize runs onto the output
  sfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (b_valid),
    .cmd_ready_o    (b_ready),
    .cmd_i          (b_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_run_end_o  (out_run_end_o),
    .out_text_end_o (out_text_end_o)
  );

  // Runs leaving the front carry one to eight bytes
  `SFR_ASSERT(a_run_len, f_valid |-> (f_cmd.len != '0 && f_cmd.len <= LenW'(MaxRun)), "bad run length")
  // End of text only on the last byte of a run
  `SFR_NEVER(a_text_end, out_valid_o && out_text_end_o && !out_run_end_o, "text end mid-run")
  // Output goes idle after a finished run when nothing is queued
  `SFR_ASSERT(a_idle, (out_valid_o && out_ready_i && out_run_end_o && !b_valid) |=> !out_valid_o, "stale output")

endmodule
